// File: rtl/core/tcsa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcsa_pkg
// Shared types, constants and helpers for the triangle circumsphere
// accumulator.
// ----------------------------------------------------------------------------
package tcsa_pkg;

  localparam int COORD_W           = 32;
  localparam int SUM_W             = 48;
  localparam int WIDE_W            = 128;
  localparam int MAG_W             = 64;
  localparam int NORM_BITS         = 62;
  localparam int UNIT_FRAC         = 30;
  localparam int THR_W             = 16;
  localparam int DEF_MAX_TRIANGLES = 65536;
  localparam logic [THR_W-1:0] THR_RESET = 16'd1;

  typedef logic signed [WIDE_W-1:0] wide_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] p_x;
    logic signed [COORD_W-1:0] p_y;
    logic signed [COORD_W-1:0] p_z;
    logic signed [COORD_W-1:0] q_x;
    logic signed [COORD_W-1:0] q_y;
    logic signed [COORD_W-1:0] q_z;
    logic signed [COORD_W-1:0] r_x;
    logic signed [COORD_W-1:0] r_y;
    logic signed [COORD_W-1:0] r_z;
    logic                      last_triangle;
  } tri_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic [COORD_W-1:0]        radius;
    logic [COORD_W-1:0]        max_radius;
    logic signed [COORD_W-1:0] mean_x;
    logic signed [COORD_W-1:0] mean_y;
    logic signed [COORD_W-1:0] mean_z;
    logic                      done_res;
  } res_item_t;

  typedef enum logic [1:0] {
    OP_MAC_ADD,
    OP_MAC_SUB,
    OP_DIV,
    OP_SQRT
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
    logic     acc_load;
  } unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_N_A,
    ST_N_B,
    ST_NORM,
    ST_L2,
    ST_LEN,
    ST_NV,
    ST_D1A,
    ST_D1B,
    ST_D2A,
    ST_D2B,
    ST_DT_A,
    ST_DT_B,
    ST_CHK,
    ST_NUM_A,
    ST_NUM_B,
    ST_TDIV,
    ST_CTR,
    ST_RAD,
    ST_RSQ,
    ST_UPD,
    ST_MEAN,
    ST_FIN
  } state_t;

  function automatic logic [1:0] axis_next(input logic [1:0] a);
    case (a)
      2'd0: return 2'd1;
      2'd1: return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] plane_a(input logic [1:0] k);
    return (k == 2'd2) ? 2'd1 : 2'd0;
  endfunction

  function automatic logic [1:0] plane_b(input logic [1:0] k);
    return (k == 2'd0) ? 2'd1 : 2'd2;
  endfunction

  function automatic wide_t sext32(input logic [31:0] x);
    return {{(WIDE_W-32){x[31]}}, x};
  endfunction

  function automatic wide_t sext33(input logic [32:0] x);
    return {{(WIDE_W-33){x[32]}}, x};
  endfunction

  function automatic wide_t sext64(input logic [63:0] x);
    return {{(WIDE_W-64){x[63]}}, x};
  endfunction

  function automatic wide_t sext48(input logic [SUM_W-1:0] x);
    return {{(WIDE_W-SUM_W){x[SUM_W-1]}}, x};
  endfunction

  function automatic logic [WIDE_W-1:0] abs_wide(input wide_t x);
    return x[WIDE_W-1] ? (~x + 1'b1) : x;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/tcsa_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcsa_in_if
// Triangle input channel: valid/ready with one triangle per beat.
// ----------------------------------------------------------------------------
interface tcsa_in_if;
  import tcsa_pkg::*;
  logic      valid;
  logic      ready;
  tri_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/tcsa_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcsa_out_if
// Result channel: valid/ready with one result per beat.
// ----------------------------------------------------------------------------
interface tcsa_out_if;
  import tcsa_pkg::*;
  logic      valid;
  logic      ready;
  res_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/tcsa_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcsa_unit
// Shared bit-serial arithmetic unit: signed multiply-accumulate, unsigned
// restoring divide and integer square root, one bit per cycle.
// ----------------------------------------------------------------------------
module tcsa_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  tcsa_pkg::unit_ctl_t           ctl,
  input  tcsa_pkg::wide_t               acc_init,
  input  tcsa_pkg::wide_t               opa,
  input  tcsa_pkg::wide_t               opb,
  output tcsa_pkg::unit_sts_t           sts,
  output tcsa_pkg::wide_t               acc,
  output logic [tcsa_pkg::WIDE_W-1:0]   quo
);
  import tcsa_pkg::*;

  localparam int AW = WIDE_W + 2;
  localparam int CW = $clog2(WIDE_W + 1);

  unit_op_t          op_r;
  logic              busy;
  logic              done_r;
  logic              sub_r;
  logic [CW-1:0]     cnt;
  logic [WIDE_W-1:0] acc_r;
  logic [WIDE_W-1:0] rb;
  logic [WIDE_W-1:0] rd;
  logic [WIDE_W-1:0] rq;
  logic [AW-1:0]     ra;

  logic [AW-1:0]     rshift;
  logic [AW-1:0]     add_a;
  logic [AW-1:0]     add_b;
  logic              add_sub;
  logic [AW-1:0]     sum;
  logic              ge;

  function automatic logic [MAG_W-1:0] mag64(input logic [MAG_W-1:0] x);
    return x[MAG_W-1] ? (~x + 1'b1) : x;
  endfunction

  assign rshift = {ra[AW-2:0], rb[WIDE_W-1]};

  always_comb begin
    case (op_r)
      OP_MAC_ADD, OP_MAC_SUB: begin
        add_a   = {2'b00, acc_r};
        add_b   = {2'b00, ra[WIDE_W-1:0]};
        add_sub = sub_r;
      end
      OP_DIV: begin
        add_a   = rshift;
        add_b   = {2'b00, rd};
        add_sub = 1'b1;
      end
      default: begin
        add_a   = ra;
        add_b   = {2'b00, rq | rb};
        add_sub = 1'b1;
      end
    endcase
  end

  assign sum = add_a + (add_sub ? ~add_b : add_b) + AW'(add_sub);
  assign ge  = ~sum[AW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        op_r <= ctl.op;
        busy <= 1'b1;
        case (ctl.op)
          OP_MAC_ADD, OP_MAC_SUB: begin
            if (ctl.acc_load) begin
              acc_r <= acc_init;
            end
            ra    <= AW'(mag64(opa[MAG_W-1:0]));
            rb    <= WIDE_W'(mag64(opb[MAG_W-1:0]));
            sub_r <= opa[MAG_W-1] ^ opb[MAG_W-1] ^ (ctl.op == OP_MAC_SUB);
            cnt   <= CW'(MAG_W);
          end
          OP_DIV: begin
            ra  <= '0;
            rb  <= opa;
            rd  <= opb;
            rq  <= '0;
            cnt <= CW'(WIDE_W);
          end
          default: begin
            ra  <= {2'b00, opa};
            rb  <= WIDE_W'(1) << (WIDE_W - 2);
            rq  <= '0;
            cnt <= CW'(WIDE_W / 2);
          end
        endcase
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy   <= 1'b0;
          done_r <= 1'b1;
        end
        case (op_r)
          OP_MAC_ADD, OP_MAC_SUB: begin
            if (rb[0]) begin
              acc_r <= sum[WIDE_W-1:0];
            end
            ra <= {ra[AW-2:0], 1'b0};
            rb <= {1'b0, rb[WIDE_W-1:1]};
          end
          OP_DIV: begin
            ra <= ge ? sum : rshift;
            rb <= {rb[WIDE_W-2:0], 1'b0};
            rq <= {rq[WIDE_W-2:0], ge};
          end
          default: begin
            if (ge) begin
              ra <= sum;
              rq <= {1'b0, rq[WIDE_W-1:1]} | rb;
            end else begin
              rq <= {1'b0, rq[WIDE_W-1:1]};
            end
            rb <= {2'b00, rb[WIDE_W-1:2]};
          end
        endcase
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done_r;
  assign acc      = acc_r;
  assign quo      = rq;

endmodule
`default_nettype wire

// File: rtl/core/triangle_circumsphere_accumulator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_circumsphere_accumulator_top
// Per-triangle circumcenter and circumradius with running mesh statistics.
// ----------------------------------------------------------------------------
// One triangle is in flight at a time: vertices.ready is high only while the
// sequencer is idle. A triangle is quickest from accept to result when its
// vertices are collinear or coincident, and slowest when all three projection
// planes are tried and it closes a mesh. The time taken is set by the single
// shared bit-serial unit, which runs up to 35 multiply-accumulates, up to 7
// divides and two square roots, plus one-bit normalization shifts. A finished
// result waits in the output register while the next triangle is accepted.
// The degenerate threshold (thr) is written through cfg_we/cfg_wdata.
module triangle_circumsphere_accumulator_top #(
  parameter int MAX_TRIANGLES = tcsa_pkg::DEF_MAX_TRIANGLES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [tcsa_pkg::THR_W-1:0]  cfg_wdata,
  tcsa_in_if.sink                     vertices,
  tcsa_out_if.source                  results
);
  import tcsa_pkg::*;

  localparam int CNT_W = $clog2(MAX_TRIANGLES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TRIANGLES);

  state_t state;
  state_t state_next;

  logic [THR_W-1:0]          thr;
  logic                      launched;
  logic                      op_done;
  logic                      in_fire;
  logic                      out_fire;
  logic                      fin_load;
  logic                      out_valid;
  res_item_t                 out_r;

  logic [1:0]                c;
  logic [1:0]                k;
  logic [1:0]                ci;
  logic [1:0]                cj;
  logic [1:0]                pa;
  logic [1:0]                pb;

  logic signed [31:0]        p   [3];
  logic signed [32:0]        v   [3];
  logic signed [32:0]        w   [3];
  logic signed [32:0]        e   [3];
  logic signed [32:0]        s1  [3];
  logic                      nneg [3];
  logic [65:0]               um  [3];
  logic [65:0]               mx;
  logic [63:0]               len;
  logic signed [31:0]        nv  [3];
  logic signed [63:0]        d1  [3];
  logic signed [63:0]        d2  [3];
  wide_t                     dt;
  wide_t                     num;
  logic signed [63:0]        t;
  logic signed [31:0]        ctr [3];
  logic [31:0]               rad;
  logic [SUM_W-1:0]          sums [3];
  logic [CNT_W-1:0]          count;
  logic [31:0]               largest;
  logic signed [31:0]        mean [3];
  logic                      last_r;

  unit_ctl_t                 ctl;
  unit_sts_t                 sts;
  wide_t                     acc_init;
  wide_t                     opa;
  wide_t                     opb;
  wide_t                     acc;
  logic [WIDE_W-1:0]         quo;

  logic [WIDE_W-1:0]         acc_abs;
  logic [WIDE_W-1:0]         dt_abs;
  logic [WIDE_W-1:0]         num_abs;
  logic [WIDE_W-1:0]         lim;
  logic                      plane_ok;
  logic                      mx_norm;
  logic [31:0]               rad_new;

  tcsa_unit u_unit (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .acc_init (acc_init),
    .opa      (opa),
    .opb      (opb),
    .sts      (sts),
    .acc      (acc),
    .quo      (quo)
  );

  assign ci       = axis_next(c);
  assign cj       = axis_next(ci);
  assign pa       = plane_a(k);
  assign pb       = plane_b(k);
  assign op_done  = launched & sts.done;
  assign in_fire  = vertices.valid & vertices.ready;
  assign out_fire = out_valid & results.ready;
  assign fin_load = (state == ST_FIN) & (~out_valid | results.ready);
  assign acc_abs  = abs_wide(acc);
  assign dt_abs   = abs_wide(dt);
  assign num_abs  = abs_wide(num);
  assign lim      = {{(WIDE_W-THR_W-16){1'b0}}, thr, 16'h0000};
  assign plane_ok = dt_abs > lim;
  assign mx_norm  = (mx[65:62] == 4'd0) & mx[61];
  assign rad_new  = (quo[WIDE_W-1:32] != '0) ? 32'hFFFF_FFFF : quo[31:0];

  assign vertices.ready = (state == ST_IDLE);
  assign results.valid  = out_valid;
  assign results.data   = out_r;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_fire) state_next = ST_N_A;
      ST_N_A:   if (op_done) state_next = ST_N_B;
      ST_N_B:   if (op_done) state_next = (c == 2'd2) ? ST_NORM : ST_N_A;
      ST_NORM: begin
        if (mx == '0) begin
          state_next = ST_CTR;
        end else if (mx_norm) begin
          state_next = ST_L2;
        end
      end
      ST_L2:    if (op_done) state_next = (c == 2'd2) ? ST_LEN : ST_L2;
      ST_LEN:   if (op_done) state_next = ST_NV;
      ST_NV:    if (op_done) state_next = (c == 2'd2) ? ST_D1A : ST_NV;
      ST_D1A:   if (op_done) state_next = ST_D1B;
      ST_D1B:   if (op_done) state_next = ST_D2A;
      ST_D2A:   if (op_done) state_next = ST_D2B;
      ST_D2B:   if (op_done) state_next = (c == 2'd2) ? ST_DT_A : ST_D1A;
      ST_DT_A:  if (op_done) state_next = ST_DT_B;
      ST_DT_B:  if (op_done) state_next = ST_CHK;
      ST_CHK: begin
        if (plane_ok) begin
          state_next = ST_NUM_A;
        end else begin
          state_next = (k == 2'd2) ? ST_CTR : ST_DT_A;
        end
      end
      ST_NUM_A: if (op_done) state_next = ST_NUM_B;
      ST_NUM_B: if (op_done) state_next = ST_TDIV;
      ST_TDIV:  if (op_done) state_next = ST_CTR;
      ST_CTR:   if (op_done) state_next = (c == 2'd2) ? ST_RAD : ST_CTR;
      ST_RAD:   if (op_done) state_next = (c == 2'd2) ? ST_RSQ : ST_RAD;
      ST_RSQ:   if (op_done) state_next = ST_UPD;
      ST_UPD:   state_next = last_r ? ST_MEAN : ST_FIN;
      ST_MEAN:  if (op_done) state_next = (c == 2'd2) ? ST_FIN : ST_MEAN;
      ST_FIN:   if (!out_valid || results.ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    logic is_op;
    logic signed [32:0] dif;
    is_op        = 1'b1;
    dif          = {ctr[c][31], ctr[c]} - {p[c][31], p[c]};
    ctl.op       = OP_MAC_ADD;
    ctl.acc_load = 1'b0;
    acc_init     = '0;
    opa          = '0;
    opb          = '0;
    case (state)
      ST_N_A: begin
        ctl.acc_load = 1'b1;
        opa          = sext33(v[ci]);
        opb          = sext33(w[cj]);
      end
      ST_N_B: begin
        ctl.op = OP_MAC_SUB;
        opa    = sext33(v[cj]);
        opb    = sext33(w[ci]);
      end
      ST_L2: begin
        ctl.acc_load = (c == 2'd0);
        opa          = {{(WIDE_W-NORM_BITS){1'b0}}, um[c][NORM_BITS-1:0]};
        opb          = {{(WIDE_W-NORM_BITS){1'b0}}, um[c][NORM_BITS-1:0]};
      end
      ST_LEN, ST_RSQ: begin
        ctl.op = OP_SQRT;
        opa    = acc;
      end
      ST_NV: begin
        ctl.op = OP_DIV;
        opa    = {{(WIDE_W-NORM_BITS-UNIT_FRAC){1'b0}}, um[c][NORM_BITS-1:0],
                  {UNIT_FRAC{1'b0}}} + {{(WIDE_W-63){1'b0}}, len[63:1]};
        opb    = {{(WIDE_W-64){1'b0}}, len};
      end
      ST_D1A, ST_D2A: begin
        ctl.acc_load = 1'b1;
        acc_init     = wide_t'(1) << (UNIT_FRAC - 1);
        opa          = sext32(nv[ci]);
        opb          = (state == ST_D1A) ? sext33(v[cj]) : sext33(w[cj]);
      end
      ST_D1B, ST_D2B: begin
        ctl.op = OP_MAC_SUB;
        opa    = sext32(nv[cj]);
        opb    = (state == ST_D1B) ? sext33(v[ci]) : sext33(w[ci]);
      end
      ST_DT_A: begin
        ctl.acc_load = 1'b1;
        opa          = sext64(d1[pa]);
        opb          = sext64(d2[pb]);
      end
      ST_DT_B: begin
        ctl.op = OP_MAC_SUB;
        opa    = sext64(d1[pb]);
        opb    = sext64(d2[pa]);
      end
      ST_NUM_A: begin
        ctl.acc_load = 1'b1;
        opa          = sext64(d2[pa]);
        opb          = sext33(e[pb]);
      end
      ST_NUM_B: begin
        ctl.op = OP_MAC_SUB;
        opa    = sext64(d2[pb]);
        opb    = sext33(e[pa]);
      end
      ST_TDIV: begin
        ctl.op = OP_DIV;
        opa    = (num_abs << 32) + dt_abs;
        opb    = dt_abs << 1;
      end
      ST_CTR: begin
        ctl.acc_load = 1'b1;
        acc_init     = (sext33(s1[c]) << 31) + (wide_t'(1) << 31);
        opa          = sext64(t);
        opb          = sext64(d1[c]);
      end
      ST_RAD: begin
        ctl.acc_load = (c == 2'd0);
        opa          = sext33(dif);
        opb          = sext33(dif);
      end
      ST_MEAN: begin
        ctl.op = OP_DIV;
        opa    = abs_wide(sext48(sums[c]));
        opb    = {{(WIDE_W-CNT_W){1'b0}}, count};
      end
      default: is_op = 1'b0;
    endcase
    ctl.start = is_op & ~launched;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      launched  <= 1'b0;
      out_valid <= 1'b0;
      thr       <= THR_RESET;
      count     <= '0;
      largest   <= '0;
      c         <= '0;
      k         <= '0;
      for (int i = 0; i < 3; i++) begin
        sums[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_we) begin
        thr <= cfg_wdata;
      end
      if (ctl.start) begin
        launched <= 1'b1;
      end else if (op_done) begin
        launched <= 1'b0;
      end
      if (fin_load) begin
        out_valid <= 1'b1;
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            p[0]   <= vertices.data.p_x;
            p[1]   <= vertices.data.p_y;
            p[2]   <= vertices.data.p_z;
            v[0]   <= 33'(vertices.data.q_x) - 33'(vertices.data.p_x);
            v[1]   <= 33'(vertices.data.q_y) - 33'(vertices.data.p_y);
            v[2]   <= 33'(vertices.data.q_z) - 33'(vertices.data.p_z);
            w[0]   <= 33'(vertices.data.r_x) - 33'(vertices.data.p_x);
            w[1]   <= 33'(vertices.data.r_y) - 33'(vertices.data.p_y);
            w[2]   <= 33'(vertices.data.r_z) - 33'(vertices.data.p_z);
            e[0]   <= 33'(vertices.data.q_x) - 33'(vertices.data.r_x);
            e[1]   <= 33'(vertices.data.q_y) - 33'(vertices.data.r_y);
            e[2]   <= 33'(vertices.data.q_z) - 33'(vertices.data.r_z);
            s1[0]  <= 33'(vertices.data.p_x) + 33'(vertices.data.q_x);
            s1[1]  <= 33'(vertices.data.p_y) + 33'(vertices.data.q_y);
            s1[2]  <= 33'(vertices.data.p_z) + 33'(vertices.data.q_z);
            last_r <= vertices.data.last_triangle;
            c      <= '0;
            k      <= '0;
            t      <= '0;
            mx     <= '0;
          end
        end
        ST_N_B: begin
          if (op_done) begin
            um[c]   <= acc_abs[65:0];
            nneg[c] <= acc[WIDE_W-1];
            if (acc_abs[65:0] > mx) begin
              mx <= acc_abs[65:0];
            end
            c <= axis_next(c);
          end
        end
        ST_NORM: begin
          if (mx != '0) begin
            if (mx[65:62] != 4'd0) begin
              mx <= mx >> 1;
              for (int i = 0; i < 3; i++) begin
                um[i] <= um[i] >> 1;
              end
            end else if (!mx[61]) begin
              mx <= mx << 1;
              for (int i = 0; i < 3; i++) begin
                um[i] <= um[i] << 1;
              end
            end
          end
        end
        ST_L2: begin
          if (op_done) c <= axis_next(c);
        end
        ST_LEN: begin
          if (op_done) len <= quo[63:0];
        end
        ST_NV: begin
          if (op_done) begin
            nv[c] <= nneg[c] ? (~quo[31:0] + 1'b1) : quo[31:0];
            c     <= axis_next(c);
          end
        end
        ST_D1B: begin
          if (op_done) d1[c] <= acc[UNIT_FRAC+63:UNIT_FRAC];
        end
        ST_D2B: begin
          if (op_done) begin
            d2[c] <= acc[UNIT_FRAC+63:UNIT_FRAC];
            c     <= axis_next(c);
          end
        end
        ST_DT_B: begin
          if (op_done) dt <= acc;
        end
        ST_CHK: begin
          if (!plane_ok) k <= k + 1'b1;
        end
        ST_NUM_B: begin
          if (op_done) num <= acc;
        end
        ST_TDIV: begin
          if (op_done) begin
            logic [63:0] tm;
            tm = (quo[WIDE_W-1:63] != '0) ? 64'h7FFF_FFFF_FFFF_FFFF : quo[63:0];
            t  <= (num[WIDE_W-1] ^ dt[WIDE_W-1]) ? (~tm + 1'b1) : tm;
          end
        end
        ST_CTR: begin
          if (op_done) begin
            if ((&acc[WIDE_W-1:63]) || ~(|acc[WIDE_W-1:63])) begin
              ctr[c] <= acc[63:32];
            end else begin
              ctr[c] <= acc[WIDE_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            c <= axis_next(c);
          end
        end
        ST_RAD: begin
          if (op_done) c <= axis_next(c);
        end
        ST_RSQ: begin
          if (op_done) rad <= rad_new;
        end
        ST_UPD: begin
          for (int i = 0; i < 3; i++) begin
            sums[i] <= sums[i] + {{(SUM_W-32){ctr[i][31]}}, ctr[i]};
            mean[i] <= '0;
          end
          if (count < CNT_MAX) begin
            count <= count + 1'b1;
          end
          if (rad > largest) begin
            largest <= rad;
          end
        end
        ST_MEAN: begin
          if (op_done) begin
            mean[c] <= sums[c][SUM_W-1] ? (~quo[31:0] + 1'b1) : quo[31:0];
            c       <= axis_next(c);
          end
        end
        ST_FIN: begin
          if (fin_load) begin
            out_r.center_x   <= ctr[0];
            out_r.center_y   <= ctr[1];
            out_r.center_z   <= ctr[2];
            out_r.radius     <= rad;
            out_r.max_radius <= largest;
            out_r.mean_x     <= mean[0];
            out_r.mean_y     <= mean[1];
            out_r.mean_z     <= mean[2];
            out_r.done_res   <= last_r;
            if (last_r) begin
              count   <= '0;
              largest <= '0;
              for (int i = 0; i < 3; i++) begin
                sums[i] <= '0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/tcsa_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcsa_checker
// Port-level checks on the accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module tcsa_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input tcsa_pkg::res_item_t out_data
);
  import tcsa_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a triangle was in progress");

  a_max_covers_radius: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.max_radius >= out_data.radius)
    else $error("max_radius below radius of the same beat");

  a_mean_only_on_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.done_res |->
      (out_data.mean_x == 0 && out_data.mean_y == 0 && out_data.mean_z == 0))
    else $error("mean nonzero on a beat that is not the last");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

endmodule

bind triangle_circumsphere_accumulator_top tcsa_checker u_tcsa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (vertices.valid),
  .in_ready  (vertices.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_data  (results.data)
);
`default_nettype wire

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the triangle circumsphere accumulator. Triangles go in over a
// valid/ready channel. A behavioral model of the block predicts center,
// radius, running maximum and mesh mean for each triangle, and the results are
// checked in order. Gaps are random on both sides, and the degenerate
// threshold is changed between phases.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tcsa_pkg::*;

  localparam int MAXTRI = 65536;
  localparam int WATCHDOG = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [THR_W-1:0] cfg_wdata = '0;

  tcsa_in_if vin ();
  tcsa_out_if vout ();

  triangle_circumsphere_accumulator_top u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .vertices(vin.sink), .results(vout.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Model state
  logic [15:0] thr_m;
  logic [47:0] sum_m [3];
  int unsigned count_m;
  logic [31:0] maxrad_m;

  res_item_t expected_q[$];
  int errors = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  int n_last = 0;
  int n_flat = 0;
  bit sink_busy = 1'b0;

  function automatic logic [127:0] isqrt128(input logic [127:0] x);
    logic [127:0] res, bitv, tt;
    res = 0;
    bitv = 128'd1 << 126;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      tt = res + bitv;
      if (x >= tt) begin
        x = x - tt;
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [127:0] mag128(input logic signed [127:0] x);
    return x[127] ? -x : x;
  endfunction

  function automatic logic signed [127:0] rnd30(input logic signed [127:0] x);
    return (x + (128'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic res_item_t predict_triangle(input tri_item_t it);
    res_item_t r;
    logic signed [127:0] p[3], v[3], w[3], e[3], s1[3], n[3], d1[3], d2[3];
    logic signed [127:0] nv[3], dt, num, tt, x, ctr[3], dd;
    logic [127:0] mx, a, l2, len, um[3], q, m, acc, rad, lim;
    logic signed [31:0] qc[3], rc[3];
    int b, i, j, k, pa, pb;
    logic signed [127:0] mean;
    p[0] = it.p_x; p[1] = it.p_y; p[2] = it.p_z;
    qc[0] = it.q_x; qc[1] = it.q_y; qc[2] = it.q_z;
    rc[0] = it.r_x; rc[1] = it.r_y; rc[2] = it.r_z;
    for (int c = 0; c < 3; c++) begin
      v[c] = 128'(signed'(qc[c])) - p[c];
      w[c] = 128'(signed'(rc[c])) - p[c];
      e[c] = 128'(signed'(qc[c])) - 128'(signed'(rc[c]));
      s1[c] = p[c] + 128'(signed'(qc[c]));
      nv[c] = 0; d1[c] = 0; d2[c] = 0;
    end
    mx = 0;
    tt = 0;
    for (int c = 0; c < 3; c++) begin
      i = (c + 1) % 3; j = (c + 2) % 3;
      n[c] = v[i] * w[j] - v[j] * w[i];
      if (mag128(n[c]) > mx) mx = mag128(n[c]);
    end
    if (mx == 0) n_flat++;
    if (mx != 0) begin
      b = 0;
      for (int z = 0; z < 128; z++) if (mx[z]) b = z + 1;
      l2 = 0;
      for (int c = 0; c < 3; c++) begin
        a = mag128(n[c]);
        a = (b > NORM_BITS) ? (a >> (b - NORM_BITS)) : (a << (NORM_BITS - b));
        um[c] = {64'd0, a[63:0]};
        l2 = l2 + um[c] * um[c];
      end
      len = isqrt128(l2);
      for (int c = 0; c < 3; c++) begin
        q = ((um[c] << UNIT_FRAC) + (len >> 1)) / len;
        nv[c] = n[c][127] ? -$signed({64'd0, q[63:0]}) : $signed({64'd0, q[63:0]});
      end
      for (int c = 0; c < 3; c++) begin
        i = (c + 1) % 3; j = (c + 2) % 3;
        d1[c] = rnd30(nv[i] * v[j] - nv[j] * v[i]);
        d2[c] = rnd30(nv[i] * w[j] - nv[j] * w[i]);
        d1[c] = 128'(signed'(d1[c][63:0]));
        d2[c] = 128'(signed'(d2[c][63:0]));
      end
      lim = {112'd0, thr_m} << 16;
      for (k = 0; k < 3; k++) begin
        pa = (k == 2) ? 1 : 0;
        pb = (k == 0) ? 1 : 2;
        dt = d1[pa] * d2[pb] - d1[pb] * d2[pa];
        if (mag128(dt) > lim) begin
          num = d2[pa] * e[pb] - d2[pb] * e[pa];
          m = ((mag128(num) << 32) + mag128(dt)) / (mag128(dt) << 1);
          if (m[127:63] != 0) m = 128'h7FFF_FFFF_FFFF_FFFF;
          tt = (num[127] != dt[127]) ? -$signed(m) : $signed(m);
          break;
        end
      end
    end
    acc = 0;
    for (int c = 0; c < 3; c++) begin
      x = ((s1[c] <<< 31) + tt * d1[c] + (128'sd1 <<< 31)) >>> 32;
      if (x < -128'sd2147483648) x = -128'sd2147483648;
      if (x > 128'sd2147483647) x = 128'sd2147483647;
      ctr[c] = x;
      dd = ctr[c] - p[c];
      acc = acc + $unsigned(dd * dd);
    end
    rad = isqrt128(acc);
    if (rad > 128'hFFFF_FFFF) rad = 128'hFFFF_FFFF;
    for (int c = 0; c < 3; c++) sum_m[c] = sum_m[c] + ctr[c][47:0];
    if (count_m < MAXTRI) count_m++;
    if (rad[31:0] > maxrad_m) maxrad_m = rad[31:0];
    r.center_x = ctr[0][31:0];
    r.center_y = ctr[1][31:0];
    r.center_z = ctr[2][31:0];
    r.radius = rad[31:0];
    r.max_radius = maxrad_m;
    r.mean_x = 0; r.mean_y = 0; r.mean_z = 0;
    r.done_res = it.last_triangle;
    if (it.last_triangle) begin
      mean = 128'(signed'(sum_m[0])) / $signed(128'(count_m));
      r.mean_x = mean[31:0];
      mean = 128'(signed'(sum_m[1])) / $signed(128'(count_m));
      r.mean_y = mean[31:0];
      mean = 128'(signed'(sum_m[2])) / $signed(128'(count_m));
      r.mean_z = mean[31:0];
      for (int c = 0; c < 3; c++) sum_m[c] = '0;
      count_m = 0;
      maxrad_m = '0;
      n_last++;
    end
    return r;
  endfunction

  function automatic int gap_len();
    int s;
    s = $urandom_range(0, 99);
    if (s < 45) return 0;
    if (s < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  task automatic send_triangle(input tri_item_t it);
    int g;
    bit rdy;
    g = gap_len();
    if (g > 0) begin
      vin.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    vin.valid <= 1'b1;
    vin.data <= it;
    do begin
      @(negedge clk);
      rdy = vin.ready;
      @(posedge clk);
    end while (!rdy);
    expected_q.push_back(predict_triangle(it));
  endtask

  task automatic drain_results();
    vin.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4000) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [15:0] t);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= t;
    @(posedge clk);
    cfg_we <= 1'b0;
    thr_m = t;
  endtask

  function automatic logic [31:0] rand_coord(input int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000))) - 32'sd1000 <<< 16;
      default: return $signed($urandom_range(0, 1 << 20)) - 32'sd524288;
    endcase
  endfunction

  function automatic tri_item_t rand_triangle(input int mode, input bit last);
    tri_item_t it;
    it.p_x = rand_coord(mode); it.p_y = rand_coord(mode); it.p_z = rand_coord(mode);
    it.q_x = rand_coord(mode); it.q_y = rand_coord(mode); it.q_z = rand_coord(mode);
    it.r_x = rand_coord(mode); it.r_y = rand_coord(mode); it.r_z = rand_coord(mode);
    if ($urandom_range(0, 19) == 0) begin
      it.r_x = it.q_x; it.r_y = it.q_y; it.r_z = it.q_z;
    end
    it.last_triangle = last;
    return it;
  endfunction

  task automatic test_directed();
    tri_item_t it;
    it = '0;
    send_triangle(it);
    it.q_x = 32'sd1 <<< 16; it.r_y = 32'sd1 <<< 16;
    send_triangle(it);
    it = '0;
    it.q_x = 32'sd2 <<< 16; it.r_x = 32'sd4 <<< 16;
    send_triangle(it);
    it = '0;
    it.p_x = 32'h7FFF_FFFF; it.p_y = 32'h8000_0000; it.p_z = 32'h7FFF_FFFF;
    it.q_x = 32'h8000_0000; it.q_y = 32'h7FFF_FFFF; it.q_z = 32'h8000_0000;
    it.r_x = 32'h8000_0000; it.r_y = 32'h8000_0000; it.r_z = 32'h7FFF_FFFF;
    send_triangle(it);
    it = '0;
    it.q_x = 32'h7FFF_FFFF; it.r_x = 32'h7FFF_FFFE; it.r_y = 32'sd1;
    send_triangle(it);
    it = '1;
    send_triangle(it);
    it = '0;
    it.q_z = 32'sd3 <<< 16; it.r_y = 32'sd5 <<< 16; it.r_z = 32'sd1;
    it.last_triangle = 1'b1;
    send_triangle(it);
    it = '0;
    it.q_y = 32'sd7 <<< 16; it.r_z = 32'sd9 <<< 16;
    it.last_triangle = 1'b1;
    send_triangle(it);
  endtask

  task automatic test_meshes(input int n, input logic [15:0] thr);
    int left;
    set_threshold(thr);
    left = $urandom_range(1, 12);
    for (int k = 0; k < n; k++) begin
      left--;
      send_triangle(rand_triangle($urandom_range(0, 2), left == 0 || k == n - 1));
      if (left == 0) left = $urandom_range(1, 12);
      if (k == n / 2) drain_results();
    end
  endtask

  always @(posedge clk) begin
    res_item_t exp_r;
    if (rst) begin
      vout.ready <= 1'b0;
    end else begin
      if (vout.valid && vout.ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, vout.data);
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          if (vout.data !== exp_r) begin
            $display("%0t: center exp %h %h %h act %h %h %h", $time, exp_r.center_x,
                     exp_r.center_y, exp_r.center_z, vout.data.center_x,
                     vout.data.center_y, vout.data.center_z);
            $display("%0t: rad/max exp %h %h act %h %h", $time, exp_r.radius,
                     exp_r.max_radius, vout.data.radius, vout.data.max_radius);
            $display("%0t: mean/done exp %h %h %h %b act %h %h %h %b", $time,
                     exp_r.mean_x, exp_r.mean_y, exp_r.mean_z, exp_r.done_res,
                     vout.data.mean_x, vout.data.mean_y, vout.data.mean_z,
                     vout.data.done_res);
            errors++;
          end
        end
      end
      vout.ready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (vin.valid && vin.ready) || (vout.valid && vout.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    vin.valid = 1'b0;
    vin.data = '0;
    thr_m = THR_RESET;
    for (int c = 0; c < 3; c++) sum_m[c] = '0;
    count_m = 0;
    maxrad_m = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_meshes(300, 16'd0);
    test_meshes(300, 16'hFFFF);
    test_meshes(300, 16'd1);
    test_meshes(300, 16'h00FF);
    drain_results();
    $display("Covered %0d results, %0d mesh ends, %0d flat triangles", results_seen,
             n_last, n_flat);
    $display("Thresholds 0, 1, 0xFF, 0xFFFF; random gaps on both sides");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// File: filelist.f
rtl/core/tcsa_pkg.sv
rtl/core/tcsa_in_if.sv
rtl/core/tcsa_out_if.sv
rtl/core/tcsa_unit.sv
rtl/core/triangle_circumsphere_accumulator_top.sv
rtl/core/tcsa_checker.sv
tb/sv/tb_top.sv
